/* rtl/binary_min_heap_priority_queue_top_defines.svh */
// Assertion macros for the heap queue.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define HMP_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("heap queue check failed");
`define HMP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("heap queue check failed");
`else
`define HMP_ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define HMP_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

/* rtl/hmp_pkg.sv */
`timescale 1ns / 1ps
package hmp_pkg;

  localparam int CAP_W = 11;
  localparam int CNT_OUT_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // read address select
  localparam logic [2:0] RD_NONE      = 3'd0;
  localparam logic [2:0] RD_LAST      = 3'd1;
  localparam logic [2:0] RD_PARENT    = 3'd2;
  localparam logic [2:0] RD_GRAND     = 3'd3;
  localparam logic [2:0] RD_LEFT      = 3'd4;
  localparam logic [2:0] RD_RIGHT     = 3'd5;
  localparam logic [2:0] RD_NEXT_LEFT = 3'd6;

  // write data select, always written at pos
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_X     = 2'd1;
  localparam logic [1:0] WR_RD    = 2'd2;
  localparam logic [1:0] WR_CHILD = 2'd3;

  localparam logic [1:0] POS_HOLD  = 2'd0;
  localparam logic [1:0] POS_UP    = 2'd1;
  localparam logic [1:0] POS_CHILD = 2'd2;

  typedef struct packed {
    logic signed [31:0] pri;
    logic signed [31:0] val;
  } entry_t;

  typedef struct packed {
    logic       accept;
    logic [2:0] rd_sel;
    logic [1:0] wr_sel;
    logic [1:0] pos_sel;
    logic       lat_x;
    logic       lat_lft;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_root;
    logic parent_root;
    logic up_less;
    logic has_left;
    logic has_right;
    logic dn_less;
    logic next_has_left;
  } sts_t;

  typedef struct packed {
    logic signed [31:0]   head_priority;
    logic signed [31:0]   head_value;
    logic                 head_valid;
    logic                 is_full;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [1:0]           status;
  } res_t;

endpackage

/* rtl/hmp_ram.sv */
`timescale 1ns / 1ps
module hmp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/hmp_ctrl.sv */
`timescale 1ns / 1ps
module hmp_ctrl
  import hmp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic mode,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP      = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DN_LAST = 3'd3;
  localparam logic [2:0] S_DN_R    = 3'd4;
  localparam logic [2:0] S_DN_CMP  = 3'd5;
  localparam logic [2:0] S_DN_FIN  = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state, state_next;
  logic       m_tvalid_next;
  logic       acc;

  assign s_tready = (state == S_IDLE);
  assign acc = s_tvalid && s_tready;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          cmd.accept = 1'b1;
          if (mode == MODE_INSERT) begin
            state_next = sts.full ? S_DONE : S_UP;
          end else if (sts.empty) begin
            state_next = S_DONE;
          end else begin
            cmd.rd_sel = RD_LAST;
            state_next = S_DN_LAST;
          end
        end
      end
      S_UP: begin
        if (sts.pos_root) begin
          cmd.wr_sel = WR_X;
          state_next = S_DONE;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_less) begin
          cmd.wr_sel = WR_RD;
          cmd.pos_sel = POS_UP;
          if (sts.parent_root) begin
            state_next = S_UP;
          end else begin
            cmd.rd_sel = RD_GRAND;
          end
        end else begin
          cmd.wr_sel = WR_X;
          state_next = S_DONE;
        end
      end
      S_DN_LAST: begin
        cmd.lat_x = 1'b1;
        if (sts.empty) begin
          state_next = S_DONE;
        end else if (!sts.has_left) begin
          cmd.wr_sel = WR_RD;
          state_next = S_DONE;
        end else begin
          cmd.rd_sel = RD_LEFT;
          state_next = S_DN_R;
        end
      end
      S_DN_R: begin
        cmd.lat_lft = 1'b1;
        if (sts.has_right) begin
          cmd.rd_sel = RD_RIGHT;
        end
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.dn_less) begin
          cmd.wr_sel = WR_CHILD;
          cmd.pos_sel = POS_CHILD;
          if (sts.next_has_left) begin
            cmd.rd_sel = RD_NEXT_LEFT;
            state_next = S_DN_R;
          end else begin
            state_next = S_DN_FIN;
          end
        end else begin
          cmd.wr_sel = WR_X;
          state_next = S_DONE;
        end
      end
      S_DN_FIN: begin
        cmd.wr_sel = WR_X;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign m_tvalid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

/* rtl/hmp_dp.sv */
`timescale 1ns / 1ps
`include "binary_min_heap_priority_queue_top_defines.svh"
module hmp_dp
  import hmp_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             in_mode,
  input  entry_t           in_entry,
  input  cmd_t             cmd,
  output sts_t             sts,
  output res_t             res
);

  localparam int IW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = (IW > CAP_W) ? IW : CAP_W;

  logic [IW-1:0]    count, count_next;
  logic [IW-1:0]    pos, pos_next;
  logic [CAP_W-1:0] cap;
  entry_t           x, lft, head;
  logic [1:0]       status;

  logic [CW-1:0] cnt_c, cap_c, eff_cap;
  logic          full, empty;
  logic [IW:0]   cnt_x, left_idx, right_idx, next_left, rd_idx;
  logic          rsel_right;
  entry_t        rd_data, sel_data, wd;
  logic [IW-1:0] sel_idx;
  logic          wr_en, rd_en;
  logic [63:0]   ram_q;

  assign cnt_c = CW'(count);
  assign cap_c = CW'(cap);
  assign eff_cap = (cap_c > CW'(DEPTH)) ? CW'(DEPTH) : cap_c;
  assign full = (cnt_c >= eff_cap);
  assign empty = (count == '0);

  assign cnt_x = {1'b0, count};
  assign left_idx = {pos, 1'b0};
  assign right_idx = {pos, 1'b1};
  assign rd_data = entry_t'(ram_q);

  assign rsel_right = (right_idx <= cnt_x) && (rd_data.pri < lft.pri);
  assign sel_data = rsel_right ? rd_data : lft;
  assign sel_idx = rsel_right ? right_idx[IW-1:0] : left_idx[IW-1:0];
  assign next_left = {sel_idx, 1'b0};

  always_comb begin
    sts.full = full;
    sts.empty = empty;
    sts.pos_root = (pos == IW'(1));
    sts.parent_root = (pos[IW-1:1] == (IW-1)'(1));
    sts.up_less = (x.pri < rd_data.pri);
    sts.has_left = (left_idx <= cnt_x);
    sts.has_right = (right_idx <= cnt_x);
    sts.dn_less = (sel_data.pri < x.pri);
    sts.next_has_left = (next_left <= cnt_x);
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST:      rd_idx = cnt_x;
      RD_PARENT:    rd_idx = {2'b00, pos[IW-1:1]};
      RD_GRAND:     rd_idx = (IW + 1)'(pos >> 2);
      RD_LEFT:      rd_idx = left_idx;
      RD_RIGHT:     rd_idx = right_idx;
      RD_NEXT_LEFT: rd_idx = next_left;
      default:      rd_idx = cnt_x;
    endcase
  end
  assign rd_en = (cmd.rd_sel != RD_NONE);

  always_comb begin
    case (cmd.wr_sel)
      WR_X:     wd = x;
      WR_RD:    wd = rd_data;
      WR_CHILD: wd = sel_data;
      default:  wd = x;
    endcase
  end
  assign wr_en = (cmd.wr_sel != WR_NONE);

  hmp_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(pos - IW'(1))),
    .wdata(wd),
    .re   (rd_en),
    .raddr(AW'(rd_idx - (IW + 1)'(1))),
    .rdata(ram_q)
  );

  always_comb begin
    count_next = count;
    pos_next = pos;
    if (cmd.accept) begin
      if (in_mode == MODE_INSERT) begin
        if (!full) begin
          count_next = count + IW'(1);
          pos_next = count + IW'(1);
        end
      end else if (!empty) begin
        count_next = count - IW'(1);
        pos_next = IW'(1);
      end
    end else begin
      case (cmd.pos_sel)
        POS_UP:    pos_next = {1'b0, pos[IW-1:1]};
        POS_CHILD: pos_next = sel_idx;
        default:   pos_next = pos;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap <= CAP_RESET;
    end else begin
      count <= count_next;
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (cmd.accept) begin
      x <= in_entry;
      if (in_mode == MODE_INSERT) begin
        status <= full ? ST_FULL : ST_DONE;
      end else begin
        status <= empty ? ST_EMPTY : ST_DONE;
      end
    end else if (cmd.lat_x) begin
      x <= rd_data;
    end
    if (cmd.lat_lft) begin
      lft <= rd_data;
    end
    // root copy for the result
    if (wr_en && (pos == IW'(1))) begin
      head <= wd;
    end
    if (cmd.load_out) begin
      res.status <= status;
      res.entry_count <= CNT_OUT_W'(count);
      res.is_full <= full;
      res.head_valid <= !empty;
      res.head_value <= empty ? '0 : head.val;
      res.head_priority <= empty ? '0 : head.pri;
    end
  end

  `HMP_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= IW'(DEPTH))
  `HMP_ASSERT_IMPL(a_write_in_heap, clk, rst, wr_en, (pos != '0) && (pos <= count))
  `HMP_ASSERT_NEXT(a_count_hold, clk, rst, !cmd.accept, $stable(count))

endmodule

/* rtl/binary_min_heap_priority_queue_top.sv */
`timescale 1ns / 1ps
// channel   dir  signals                          contents
// s_        in   s_tvalid s_tready s_tdata s_tuser  value, priority_req; tuser mode
// m_        out  m_tvalid m_tready m_tdata          status .. head_priority
// cfg_      in   cfg_we cfg_wdata                   capacity, no read-back
//
// Insert: one parent read and compare per level. Removal: two child reads
// per level on the single read port of the heap RAM. Rejected items skip
// the heap walk and go straight to the result.
// One item at a time; s_tready is high only while idle.
// A held result stalls completion of the next item in its final cycle.
// Reset empties the heap and sets capacity to 1024; RAM is not cleared.
module binary_min_heap_priority_queue_top
  import hmp_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,   // value[31:0], priority_req[63:32]
  input  logic             s_tuser,   // mode
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [79:0]      m_tdata,   // status, entry_count, is_full, head_valid,
                                      // head_value, head_priority, pad
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  cmd_t   cmd;
  sts_t   sts;
  res_t   res;
  entry_t in_entry;

  assign in_entry = entry_t'(s_tdata);

  hmp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .mode    (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  hmp_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_mode  (s_tuser),
    .in_entry (in_entry),
    .cmd      (cmd),
    .sts      (sts),
    .res      (res)
  );

  assign m_tdata = {1'b0, res.head_priority, res.head_value, res.head_valid,
                    res.is_full, res.entry_count, res.status};

endmodule
